/* design/spi_pkg.sv */
package spi_pkg;

  localparam int unsigned ADDR_BITS_DEF   = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned FRAC_BITS_DEF   = 16;

  localparam int unsigned REQ_BITS = 3;
  localparam int unsigned CFG_INDEX_BITS = 3;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_TICK    = 3'd0,
    REQ_TRIGGER = 3'd1,
    REQ_STOP    = 3'd2,
    REQ_WRITE   = 3'd3,
    REQ_SET_POS = 3'd4
  } req_type_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOOP_ENABLE = 3'd0,
    CFG_START_FRAME = 3'd1,
    CFG_END_FRAME   = 3'd2,
    CFG_STEP_RATE   = 3'd3,
    CFG_STEREO_MODE = 3'd4,
    CFG_OFFLINE     = 3'd5
  } cfg_index_t;

  // control for the tick held between the address stage and the blend stage
  typedef struct packed {
    logic valid;
    logic active;
    logic mono;
    logic playing;
  } tick_ctrl_t;

endpackage

/* design/spi_cfg_regs.sv */
module spi_cfg_regs #(
  parameter int unsigned ADDR_BITS = spi_pkg::ADDR_BITS_DEF,
  parameter int unsigned FRAC_BITS = spi_pkg::FRAC_BITS_DEF,
  parameter int unsigned CFG_DATA_BITS = (ADDR_BITS + 1 > FRAC_BITS + 4) ?
                                         ADDR_BITS + 1 : FRAC_BITS + 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  wr_en,
  input  logic [spi_pkg::CFG_INDEX_BITS-1:0]    wr_index,
  input  logic [CFG_DATA_BITS-1:0]              wr_data,
  output logic                                  loop_enable,
  output logic [ADDR_BITS-1:0]                  start_frame,
  output logic [ADDR_BITS:0]                    end_frame,
  output logic [FRAC_BITS+3:0]                  step_rate,
  output logic                                  stereo_mode,
  output logic                                  offline
);

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_enable <= 1'b0;
      start_frame <= '0;
      end_frame   <= (ADDR_BITS+1)'(1) << ADDR_BITS;
      step_rate   <= (FRAC_BITS+4)'(1) << FRAC_BITS;
      stereo_mode <= 1'b1;
      offline     <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        spi_pkg::CFG_LOOP_ENABLE: loop_enable <= wr_data[0];
        spi_pkg::CFG_START_FRAME: start_frame <= wr_data[ADDR_BITS-1:0];
        spi_pkg::CFG_END_FRAME:   end_frame   <= wr_data[ADDR_BITS:0];
        spi_pkg::CFG_STEP_RATE:   step_rate   <= wr_data[FRAC_BITS+3:0];
        spi_pkg::CFG_STEREO_MODE: stereo_mode <= wr_data[0];
        spi_pkg::CFG_OFFLINE:     offline     <= wr_data[0];
        default: begin
        end
      endcase
    end
  end

endmodule

/* design/spi_mem.sv */
module spi_mem #(
  parameter int unsigned ADDR_BITS = spi_pkg::ADDR_BITS_DEF,
  parameter int unsigned DATA_BITS = spi_pkg::SAMPLE_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic                 rd_en,
  input  logic [ADDR_BITS-1:0] rd_addr_a,
  input  logic [ADDR_BITS-1:0] rd_addr_b,
  output logic [DATA_BITS-1:0] rd_data_a,
  output logic [DATA_BITS-1:0] rd_data_b
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

/* design/spi_ctrl.sv */
module spi_ctrl #(
  parameter int unsigned ADDR_BITS = spi_pkg::ADDR_BITS_DEF,
  parameter int unsigned FRAC_BITS = spi_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [spi_pkg::REQ_BITS-1:0]       req_type,
  input  logic [ADDR_BITS+FRAC_BITS-1:0]     new_position,
  input  logic                               loop_enable,
  input  logic [ADDR_BITS-1:0]               start_frame,
  input  logic [ADDR_BITS:0]                 end_frame,
  input  logic [FRAC_BITS+3:0]               step_rate,
  input  logic                               stereo_mode,
  input  logic                               offline,
  input  logic                               blend_ready,
  output logic                               rd_en,
  output logic [ADDR_BITS-1:0]               rd_below,
  output logic [ADDR_BITS-1:0]               rd_above,
  output spi_pkg::tick_ctrl_t                tick,
  output logic [FRAC_BITS-1:0]               tick_frac
);

  localparam int unsigned POS_BITS = ADDR_BITS + 1 + FRAC_BITS;

  logic [POS_BITS-1:0] position;
  logic [POS_BITS-1:0] position_next;
  logic                playing;
  logic                playing_next;

  logic                tick_accept;
  logic [POS_BITS-1:0] start_pos;
  logic                wrap;
  logic [POS_BITS-1:0] pos_eff;
  logic                playing_eff;
  logic [ADDR_BITS:0]  below;
  logic [ADDR_BITS+1:0] above_sum;
  logic                above_wrap;
  logic [POS_BITS-1:0] pos_step;

  always_comb begin
    tick_accept = accept && (req_type == spi_pkg::REQ_TICK);
    start_pos   = {1'b0, start_frame, {FRAC_BITS{1'b0}}};
    wrap        = position[POS_BITS-1:FRAC_BITS] >= end_frame;
    pos_eff     = wrap ? start_pos : position;
    playing_eff = playing && !(wrap && !loop_enable);
    below       = pos_eff[POS_BITS-1:FRAC_BITS];
    above_sum   = {1'b0, below} + (ADDR_BITS+2)'(1);
    above_wrap  = above_sum >= {1'b0, end_frame};
    rd_en       = tick_accept;
    rd_below    = below[ADDR_BITS-1:0];
    rd_above    = above_wrap ? start_frame : above_sum[ADDR_BITS-1:0];
    pos_step    = pos_eff + POS_BITS'(step_rate);

    position_next = position;
    playing_next  = playing;
    if (accept) begin
      unique case (req_type)
        spi_pkg::REQ_TICK: begin
          if (!offline) begin
            position_next = pos_step;
            playing_next  = playing_eff;
          end
        end
        spi_pkg::REQ_TRIGGER: begin
          position_next = start_pos;
          playing_next  = 1'b1;
        end
        spi_pkg::REQ_STOP: playing_next = 1'b0;
        spi_pkg::REQ_SET_POS: position_next = {1'b0, new_position};
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      playing  <= 1'b0;
    end else begin
      position <= position_next;
      playing  <= playing_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick <= '0;
    end else if (tick_accept) begin
      tick.valid   <= 1'b1;
      tick.active  <= !offline && playing_eff;
      tick.mono    <= !stereo_mode;
      tick.playing <= offline ? playing : playing_eff;
    end else if (blend_ready) begin
      tick.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      tick_frac <= pos_eff[FRAC_BITS-1:0];
    end
  end

  a_trigger_starts: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == spi_pkg::REQ_TRIGGER |=>
      playing && position[POS_BITS-1:FRAC_BITS] == {1'b0, $past(start_frame)})
    else $error("trigger did not restart the voice");

  a_stop_clears: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == spi_pkg::REQ_STOP |=> !playing)
    else $error("stop left the voice playing");

  a_offline_frozen: assert property (@(posedge clk) disable iff (rst)
    tick_accept && offline |=> $stable(position) && $stable(playing))
    else $error("offline tick changed the voice state");

endmodule

/* design/spi_blend.sv */
module spi_blend #(
  parameter int unsigned SAMPLE_BITS = spi_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = spi_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  spi_pkg::tick_ctrl_t           tick,
  input  logic [FRAC_BITS-1:0]          tick_frac,
  input  logic [SAMPLE_BITS-1:0]        left_below,
  input  logic [SAMPLE_BITS-1:0]        left_above,
  input  logic [SAMPLE_BITS-1:0]        right_below,
  input  logic [SAMPLE_BITS-1:0]        right_above,
  output logic                          blend_ready,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic signed [SAMPLE_BITS-1:0] left_out,
  output logic signed [SAMPLE_BITS-1:0] right_out,
  output logic                          playing_flag
);

  localparam int unsigned SUM_BITS = SAMPLE_BITS + FRAC_BITS + 2;

  logic signed [SAMPLE_BITS:0]    diff_l;
  logic signed [SAMPLE_BITS:0]    diff_r;
  logic signed [FRAC_BITS:0]      weight;
  logic signed [SUM_BITS-1:0]     sum_l;
  logic signed [SUM_BITS-1:0]     sum_r;
  logic [SAMPLE_BITS-1:0]         mix_l;
  logic [SAMPLE_BITS-1:0]         mix_r;

  // lo + (hi - lo) * f, floored by dropping the fraction bits
  always_comb begin
    diff_l = {left_above[SAMPLE_BITS-1], left_above}
           - {left_below[SAMPLE_BITS-1], left_below};
    diff_r = {right_above[SAMPLE_BITS-1], right_above}
           - {right_below[SAMPLE_BITS-1], right_below};
    weight = {1'b0, tick_frac};
    sum_l  = diff_l * weight
           + $signed({{2{left_below[SAMPLE_BITS-1]}}, left_below, {FRAC_BITS{1'b0}}});
    sum_r  = diff_r * weight
           + $signed({{2{right_below[SAMPLE_BITS-1]}}, right_below, {FRAC_BITS{1'b0}}});
    mix_l  = sum_l[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
    mix_r  = sum_r[FRAC_BITS+SAMPLE_BITS-1:FRAC_BITS];
  end

  assign blend_ready = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (blend_ready) begin
      res_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (blend_ready) begin
      left_out     <= tick.active ? mix_l : '0;
      right_out    <= !tick.active ? '0 : (tick.mono ? mix_l : mix_r);
      playing_flag <= tick.playing;
    end
  end

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !playing_flag |-> left_out == '0 && right_out == '0)
    else $error("stopped voice gave a nonzero sample");

  a_mono_copy: assert property (@(posedge clk) disable iff (rst)
    blend_ready && tick.valid && tick.mono |=> res_valid && left_out == right_out)
    else $error("mono beat has differing channels");

endmodule

/* design/sample_playback_interpolator.sv */
// channel   | handshake            | beat carries
// ----------+----------------------+--------------------------------------------------
// request   | req_valid/req_ready  | req_type, frame_address, left_in, right_in,
//           |                      | new_position
// result    | res_valid/res_ready  | left_out, right_out, playing_flag
// config    | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// One request beat per cycle while req_ready is high. A tick's result beat goes through the
// sample memory read and the tick register, then the blend into the output register.
// Reset clears position, playing and the registers to their defaults; memory is not cleared.
// res_ready low holds the output; one more tick waits in the read stage, then req_ready drops.
// cfg_ready is always high.
module sample_playback_interpolator #(
  parameter int unsigned ADDR_BITS   = spi_pkg::ADDR_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = spi_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned FRAC_BITS   = spi_pkg::FRAC_BITS_DEF,
  parameter int unsigned CFG_DATA_BITS = (ADDR_BITS + 1 > FRAC_BITS + 4) ?
                                         ADDR_BITS + 1 : FRAC_BITS + 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               req_valid,
  output logic                               req_ready,
  input  logic [spi_pkg::REQ_BITS-1:0]       req_type,
  input  logic [ADDR_BITS-1:0]               frame_address,
  input  logic signed [SAMPLE_BITS-1:0]      left_in,
  input  logic signed [SAMPLE_BITS-1:0]      right_in,
  input  logic [ADDR_BITS+FRAC_BITS-1:0]     new_position,
  output logic                               res_valid,
  input  logic                               res_ready,
  output logic signed [SAMPLE_BITS-1:0]      left_out,
  output logic signed [SAMPLE_BITS-1:0]      right_out,
  output logic                               playing_flag,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [spi_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]           cfg_data
);

  logic                   loop_enable;
  logic [ADDR_BITS-1:0]   start_frame;
  logic [ADDR_BITS:0]     end_frame;
  logic [FRAC_BITS+3:0]   step_rate;
  logic                   stereo_mode;
  logic                   offline;

  logic                   accept;
  logic                   mem_wr;
  logic                   rd_en;
  logic [ADDR_BITS-1:0]   rd_below;
  logic [ADDR_BITS-1:0]   rd_above;
  spi_pkg::tick_ctrl_t    tick;
  logic [FRAC_BITS-1:0]   tick_frac;
  logic                   blend_ready;
  logic [SAMPLE_BITS-1:0] left_below;
  logic [SAMPLE_BITS-1:0] left_above;
  logic [SAMPLE_BITS-1:0] right_below;
  logic [SAMPLE_BITS-1:0] right_above;

  assign cfg_ready = 1'b1;
  assign req_ready = !tick.valid || blend_ready;
  assign accept    = req_valid && req_ready;
  assign mem_wr    = accept && (req_type == spi_pkg::REQ_WRITE);

  spi_cfg_regs #(
    .ADDR_BITS     (ADDR_BITS),
    .FRAC_BITS     (FRAC_BITS),
    .CFG_DATA_BITS (CFG_DATA_BITS)
  ) u_cfg (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (cfg_valid && cfg_ready),
    .wr_index    (cfg_index),
    .wr_data     (cfg_data),
    .loop_enable (loop_enable),
    .start_frame (start_frame),
    .end_frame   (end_frame),
    .step_rate   (step_rate),
    .stereo_mode (stereo_mode),
    .offline     (offline)
  );

  spi_ctrl #(
    .ADDR_BITS (ADDR_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .req_type     (req_type),
    .new_position (new_position),
    .loop_enable  (loop_enable),
    .start_frame  (start_frame),
    .end_frame    (end_frame),
    .step_rate    (step_rate),
    .stereo_mode  (stereo_mode),
    .offline      (offline),
    .blend_ready  (blend_ready),
    .rd_en        (rd_en),
    .rd_below     (rd_below),
    .rd_above     (rd_above),
    .tick         (tick),
    .tick_frac    (tick_frac)
  );

  spi_mem #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (SAMPLE_BITS)
  ) u_left_mem (
    .clk       (clk),
    .wr_en     (mem_wr),
    .wr_addr   (frame_address),
    .wr_data   (left_in),
    .rd_en     (rd_en),
    .rd_addr_a (rd_below),
    .rd_addr_b (rd_above),
    .rd_data_a (left_below),
    .rd_data_b (left_above)
  );

  spi_mem #(
    .ADDR_BITS (ADDR_BITS),
    .DATA_BITS (SAMPLE_BITS)
  ) u_right_mem (
    .clk       (clk),
    .wr_en     (mem_wr),
    .wr_addr   (frame_address),
    .wr_data   (right_in),
    .rd_en     (rd_en),
    .rd_addr_a (rd_below),
    .rd_addr_b (rd_above),
    .rd_data_a (right_below),
    .rd_data_b (right_above)
  );

  spi_blend #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_blend (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .tick_frac    (tick_frac),
    .left_below   (left_below),
    .left_above   (left_above),
    .right_below  (right_below),
    .right_above  (right_above),
    .blend_ready  (blend_ready),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .left_out     (left_out),
    .right_out    (right_out),
    .playing_flag (playing_flag)
  );

endmodule

/* tb/tb_sample_playback_interpolator.sv */
`timescale 1ns / 1ps

module tb_sample_playback_interpolator;

  localparam int unsigned AB = spi_pkg::ADDR_BITS_DEF;
  localparam int unsigned SB = spi_pkg::SAMPLE_BITS_DEF;
  localparam int unsigned FB = spi_pkg::FRAC_BITS_DEF;
  localparam int unsigned RB = spi_pkg::REQ_BITS;
  localparam int unsigned XB = spi_pkg::CFG_INDEX_BITS;
  localparam int unsigned CW = (AB + 1 > FB + 4) ? AB + 1 : FB + 4;
  localparam int unsigned PW = AB + FB + 1;
  localparam int unsigned SW = SB + FB + 1;
  localparam int unsigned DEPTH = 1 << AB;
  localparam int unsigned REG_COUNT = spi_pkg::CFG_OFFLINE + 1;
  localparam int unsigned PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 105;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 6;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam logic [RB-1:0] REQ_UNUSED_LO = RB'(spi_pkg::REQ_SET_POS + 1);
  localparam logic [RB-1:0] REQ_UNUSED_HI = '1;

  typedef struct {
    logic [RB-1:0]        kind;
    logic [AB-1:0]        addr;
    logic signed [SB-1:0] l;
    logic signed [SB-1:0] r;
    logic [AB+FB-1:0]     npos;
  } req_beat_t;

  typedef struct {
    logic signed [SB-1:0] l;
    logic signed [SB-1:0] r;
    logic                 flag;
  } frame_t;

  typedef enum {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    req_beat_t           beat;
    spi_pkg::cfg_index_t idx;
    logic [CW-1:0]       val;
    bit                  typed;
    frame_t              want;
  } row_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  logic [RB-1:0]               req_type = '0;
  logic [AB-1:0]               frame_address = '0;
  logic signed [SB-1:0]        left_in = '0;
  logic signed [SB-1:0]        right_in = '0;
  logic [AB+FB-1:0]            new_position = '0;
  logic                        res_valid;
  logic                        res_ready = 1'b0;
  logic signed [SB-1:0]        left_out;
  logic signed [SB-1:0]        right_out;
  logic                        playing_flag;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [XB-1:0]               cfg_index = '0;
  logic [CW-1:0]               cfg_data = '0;

  sample_playback_interpolator dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic signed [SB-1:0] left_mem [DEPTH];
  logic signed [SB-1:0] right_mem [DEPTH];
  bit                   written [DEPTH];
  logic [PW-1:0]        position = '0;
  bit                   playing = 1'b0;
  bit                   loop_en = 1'b0;
  logic [AB-1:0]        start_fr = '0;
  logic [AB:0]          end_fr = (AB+1)'(DEPTH);
  logic [FB+3:0]        rate = (FB+4)'(1) << FB;
  bit                   stereo = 1'b1;
  bit                   offline_mode = 1'b0;

  frame_t pending_frames [$];
  row_t   directed [$];
  int     mismatches = 0;
  int     frames_checked = 0;
  int     items_sent = 0;
  int     ticks_sent = 0;
  int     writes_sent = 0;
  int     phases_run = 0;
  int     stall_cycles = 0;
  bit     burst = 1'b0;
  bit     hold_start = 1'b0;

  function automatic logic [SB-1:0] blend(logic [SB-1:0] lo, logic [SB-1:0] hi,
                                          logic [FB-1:0] frac);
    logic [SB-1:0]   bias;
    logic [SW-1:0]   a;
    logic [SW-1:0]   b;
    logic [SW-1:0]   f;
    logic [SW-1:0]   sum;
    bias = {1'b1, {(SB-1){1'b0}}};
    a = SW'(lo ^ bias);
    b = SW'(hi ^ bias);
    f = SW'(frac);
    sum = a * ((SW'(1) << FB) - f) + b * f;
    return sum[SB+FB-1:FB] ^ bias;
  endfunction

  // wrap at the end frame, then pick the two frames around the position
  function automatic bit locate_frames(output logic [PW-1:0] pos_now, output bit live,
                                       output logic [AB-1:0] lo_idx,
                                       output logic [AB-1:0] hi_idx);
    logic [AB:0] below;
    logic [AB:0] above;
    pos_now = position;
    live = playing;
    if (pos_now[PW-1:FB] >= end_fr) begin
      pos_now = PW'(start_fr) << FB;
      if (!loop_en) live = 1'b0;
    end
    below = pos_now[PW-1:FB];
    above = below + (AB+1)'(1);
    if (above >= end_fr) above = {1'b0, start_fr};
    lo_idx = below[AB-1:0];
    hi_idx = above[AB-1:0];
    return live;
  endfunction

  function automatic void advance_voice(req_beat_t b);
    frame_t        f;
    logic [PW-1:0] p;
    bit            live;
    logic [AB-1:0] lo;
    logic [AB-1:0] hi;
    case (b.kind)
      spi_pkg::REQ_TRIGGER: begin
        position = PW'(start_fr) << FB;
        playing = 1'b1;
      end
      spi_pkg::REQ_STOP: playing = 1'b0;
      spi_pkg::REQ_WRITE: begin
        left_mem[b.addr] = b.l;
        right_mem[b.addr] = b.r;
        written[b.addr] = 1'b1;
      end
      spi_pkg::REQ_SET_POS: position = PW'(b.npos);
      spi_pkg::REQ_TICK: begin
        f.l = '0;
        f.r = '0;
        f.flag = playing;
        if (!offline_mode) begin
          void'(locate_frames(p, live, lo, hi));
          position = p;
          playing = live;
          f.flag = live;
          if (live) begin
            f.l = blend(left_mem[lo], left_mem[hi], p[FB-1:0]);
            f.r = stereo ? blend(right_mem[lo], right_mem[hi], p[FB-1:0]) : f.l;
          end
          position = position + PW'(rate);
        end
        pending_frames.insert(pending_frames.size(), f);
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(req_beat_t b);
    if (!burst) begin
      while ($urandom_range(0, 99) < 24) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req_type <= b.kind;
    frame_address <= b.addr;
    left_in <= b.l;
    right_in <= b.r;
    new_position <= b.npos;
    do @(posedge clk); while (!req_ready);
    advance_voice(b);
    items_sent++;
    if (b.kind == spi_pkg::REQ_TICK) ticks_sent++;
    if (b.kind == spi_pkg::REQ_WRITE) writes_sent++;
  endtask

  // write any frame the next tick would read that holds no sample yet
  task automatic fill_gaps();
    logic [PW-1:0] p;
    bit            live;
    logic [AB-1:0] idx [2];
    req_beat_t     w;
    if (offline_mode || !locate_frames(p, live, idx[0], idx[1])) return;
    for (int k = 0; k < 2; k++) begin
      if (!written[idx[k]]) begin
        w.kind = spi_pkg::REQ_WRITE;
        w.addr = idx[k];
        w.l = SB'($urandom);
        w.r = SB'($urandom);
        w.npos = (AB+FB)'($urandom);
        send_req(w);
      end
    end
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(spi_pkg::cfg_index_t idx, logic [CW-1:0] v, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
    case (idx)
      spi_pkg::CFG_LOOP_ENABLE: loop_en = v[0];
      spi_pkg::CFG_START_FRAME: start_fr = v[AB-1:0];
      spi_pkg::CFG_END_FRAME:   end_fr = v[AB:0];
      spi_pkg::CFG_STEP_RATE:   rate = v[FB+3:0];
      spi_pkg::CFG_STEREO_MODE: stereo = v[0];
      spi_pkg::CFG_OFFLINE:     offline_mode = v[0];
      default: ;
    endcase
  endtask

  function automatic row_t req_row(logic [RB-1:0] kind, int addr = 0, int l = 0, int r = 0,
                                   logic [AB+FB-1:0] npos = '0);
    row_t x;
    x.kind = ROW_REQ;
    x.beat.kind = kind;
    x.beat.addr = AB'(addr);
    x.beat.l = SB'(l);
    x.beat.r = SB'(r);
    x.beat.npos = npos;
    x.idx = spi_pkg::CFG_LOOP_ENABLE;
    x.val = '0;
    x.typed = 1'b0;
    x.want.l = '0;
    x.want.r = '0;
    x.want.flag = 1'b0;
    return x;
  endfunction

  function automatic row_t tick_row(int l, int r, logic flag);
    row_t x;
    x = req_row(spi_pkg::REQ_TICK);
    x.typed = 1'b1;
    x.want.l = SB'(l);
    x.want.r = SB'(r);
    x.want.flag = flag;
    return x;
  endfunction

  function automatic row_t cfg_row(spi_pkg::cfg_index_t idx, int v);
    row_t x;
    x = req_row(spi_pkg::REQ_TICK);
    x.kind = ROW_CFG;
    x.idx = idx;
    x.val = CW'(v);
    return x;
  endfunction

  initial forever begin
    @(posedge clk);
    if (hold_start) begin
      hold_start = 1'b0;
      res_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clk);
    end
    res_ready <= burst || ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin : check_results
    frame_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_frames.size() == 0) begin
        $error("result beat with nothing expected: left_out %0d right_out %0d playing_flag %0b",
               left_out, right_out, playing_flag);
        mismatches++;
      end else begin
        want = pending_frames.pop_front();
        frames_checked++;
        if (left_out !== want.l) begin
          $error("left_out: expected %0d, got %0d", want.l, left_out);
          mismatches++;
        end
        if (right_out !== want.r) begin
          $error("right_out: expected %0d, got %0d", want.r, right_out);
          mismatches++;
        end
        if (playing_flag !== want.flag) begin
          $error("playing_flag: expected %0b, got %0b", want.flag, playing_flag);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    req_beat_t     b;
    int            pick;
    int            span;
    int            base;
    int            win_lo;
    int            win_hi;
    logic [CW-1:0] setting [REG_COUNT];

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    directed = '{
      tick_row(0, 0, 1'b0),
      req_row(spi_pkg::REQ_WRITE, 0, 32767, -32768),
      req_row(spi_pkg::REQ_WRITE, 1, -32768, 32767),
      req_row(spi_pkg::REQ_WRITE, 2, 1000, -1000),
      req_row(spi_pkg::REQ_WRITE, '1, 21845, -21846),
      req_row(spi_pkg::REQ_TRIGGER),
      tick_row(32767, -32768, 1'b1),
      tick_row(-32768, 32767, 1'b1),
      req_row(spi_pkg::REQ_SET_POS, 0, 0, 0, 32'h0000_8000),
      req_row(spi_pkg::REQ_TICK),
      req_row(spi_pkg::REQ_SET_POS, 0, 0, 0, '1),
      req_row(spi_pkg::REQ_TICK),
      tick_row(0, 0, 1'b0),
      req_row(REQ_UNUSED_LO, '1, -1, -1, '1),
      req_row(RB'(REQ_UNUSED_LO + 1)),
      req_row(REQ_UNUSED_HI),
      cfg_row(spi_pkg::CFG_OFFLINE, 1),
      req_row(spi_pkg::REQ_TRIGGER),
      tick_row(0, 0, 1'b1),
      req_row(spi_pkg::REQ_STOP),
      tick_row(0, 0, 1'b0),
      req_row(spi_pkg::REQ_TRIGGER),
      cfg_row(spi_pkg::CFG_OFFLINE, 0),
      cfg_row(spi_pkg::CFG_STEREO_MODE, 0),
      tick_row(32767, 32767, 1'b1),
      cfg_row(spi_pkg::CFG_STEREO_MODE, 1),
      cfg_row(spi_pkg::CFG_LOOP_ENABLE, 1),
      cfg_row(spi_pkg::CFG_END_FRAME, 2),
      req_row(spi_pkg::REQ_TRIGGER),
      tick_row(32767, -32768, 1'b1),
      tick_row(-32768, 32767, 1'b1),
      tick_row(32767, -32768, 1'b1),
      cfg_row(spi_pkg::CFG_STEP_RATE, 1 << (FB - 1)),
      req_row(spi_pkg::REQ_TICK),
      req_row(spi_pkg::REQ_TICK)
    };

    foreach (directed[i]) begin
      if (directed[i].kind == ROW_CFG) begin
        if (i == 0 || directed[i-1].kind != ROW_CFG) settle();
        cfg_write(directed[i].idx, directed[i].val,
                  i + 1 == directed.size() || directed[i+1].kind != ROW_CFG);
      end else begin
        send_req(directed[i].beat);
        if (directed[i].typed) pending_frames[pending_frames.size()-1] = directed[i].want;
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      burst = 1'b0;
      span = $urandom_range(1, 48);
      case ($urandom_range(0, 3))
        0: base = $urandom_range(DEPTH - 64, DEPTH - 1);
        1: base = $urandom_range(0, 63);
        default: base = $urandom_range(0, DEPTH - 1);
      endcase
      setting[spi_pkg::CFG_LOOP_ENABLE] = CW'($urandom_range(0, 1));
      setting[spi_pkg::CFG_START_FRAME] = CW'(base);
      setting[spi_pkg::CFG_END_FRAME] = CW'(($urandom_range(0, 7) == 0) ?
                                            $urandom_range(0, DEPTH) :
                                            (base + span > DEPTH) ? DEPTH : base + span);
      case ($urandom_range(0, 3))
        0: setting[spi_pkg::CFG_STEP_RATE] = CW'(1 << FB);
        1: setting[spi_pkg::CFG_STEP_RATE] = CW'($urandom_range(1, 2 << FB));
        2: setting[spi_pkg::CFG_STEP_RATE] = CW'($urandom_range(0, (1 << (FB + 4)) - 1));
        default: setting[spi_pkg::CFG_STEP_RATE] = CW'($urandom_range(0, 1 << (FB - 2)));
      endcase
      setting[spi_pkg::CFG_STEREO_MODE] = CW'($urandom_range(0, 1));
      setting[spi_pkg::CFG_OFFLINE] = CW'($urandom_range(0, 5) == 0);
      case (ph)
        0: begin
          setting[spi_pkg::CFG_LOOP_ENABLE] = CW'(0);
          setting[spi_pkg::CFG_START_FRAME] = CW'(0);
          setting[spi_pkg::CFG_END_FRAME] = CW'(DEPTH);
          setting[spi_pkg::CFG_STEP_RATE] = CW'((1 << (FB + 4)) - 1);
          setting[spi_pkg::CFG_STEREO_MODE] = CW'(1);
          setting[spi_pkg::CFG_OFFLINE] = CW'(0);
        end
        1: begin
          setting[spi_pkg::CFG_LOOP_ENABLE] = CW'(1);
          setting[spi_pkg::CFG_START_FRAME] = CW'(DEPTH - 1);
          setting[spi_pkg::CFG_END_FRAME] = CW'(0);
          setting[spi_pkg::CFG_STEP_RATE] = CW'(0);
          setting[spi_pkg::CFG_STEREO_MODE] = CW'(0);
          setting[spi_pkg::CFG_OFFLINE] = CW'(0);
        end
        2: setting[spi_pkg::CFG_OFFLINE] = CW'(1);
        default: ;
      endcase
      for (int k = 0; k < REG_COUNT; k++) begin
        cfg_write(spi_pkg::cfg_index_t'(k), setting[k], k == REG_COUNT - 1);
      end
      phases_run++;

      win_lo = start_fr;
      win_hi = (end_fr > start_fr) ? end_fr - 1 : start_fr;
      if (ph == 4) hold_start = 1'b1;
      burst = (ph == 6);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        b.addr = AB'($urandom);
        b.l = SB'($urandom);
        b.r = SB'($urandom);
        b.npos = (AB+FB)'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 58) begin
          b.kind = spi_pkg::REQ_TICK;
        end else if (pick < 66) begin
          b.kind = spi_pkg::REQ_TRIGGER;
        end else if (pick < 70) begin
          b.kind = spi_pkg::REQ_STOP;
        end else if (pick < 82) begin
          b.kind = spi_pkg::REQ_WRITE;
          if ($urandom_range(0, 4) != 0) b.addr = AB'($urandom_range(win_lo, win_hi));
        end else if (pick < 94) begin
          b.kind = spi_pkg::REQ_SET_POS;
          if ($urandom_range(0, 6) != 0) begin
            b.npos = {AB'($urandom_range(win_lo, win_hi)), FB'($urandom)};
          end
        end else begin
          b.kind = RB'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
        end
        if (b.kind == spi_pkg::REQ_TICK) fill_gaps();
        send_req(b);
      end
    end

    settle();
    $display("Sent %0d request beats (%0d ticks, %0d frame writes), checked %0d result beats.",
             items_sent, ticks_sent, writes_sent, frames_checked);
    $display("Ran %0d register settings incl. rate, loop, mono and offline extremes; %0d mismatches.",
             phases_run, mismatches);
    if (mismatches == 0 && pending_frames.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sample_playback_interpolator.f */
design/spi_pkg.sv
design/spi_cfg_regs.sv
design/spi_mem.sv
design/spi_ctrl.sv
design/spi_blend.sv
design/sample_playback_interpolator.sv
tb/tb_sample_playback_interpolator.sv
